FILE: hdl/dual_motor_duty_ramp_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual motor duty ramp
// Shared property templates; the user scope provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_DUTY_RAMP_DEFINES_SVH
`define DUAL_MOTOR_DUTY_RAMP_DEFINES_SVH

// same-cycle implication
`define DMDR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DMDR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/dmdr_pkg.sv
// ----------------------------------------------------------------------------
// dmdr_pkg
// Widths, register map, reset values and command codes of the duty ramp.
// ----------------------------------------------------------------------------
package dmdr_pkg;

	localparam int DUTY_BITS_DEF = 8;
	localparam int DUTY_OUT_W    = 8;
	localparam int CFG_W         = 8;
	localparam int CMD_W         = 3;
	localparam int SPEED_W       = 16;
	localparam int PDATA_W       = 32;
	localparam int PADDR_W       = 3;
	localparam int REG_IDX_W     = 1;

	localparam logic [CFG_W-1:0] FLOOR_RST = 8'd0;
	localparam logic [CFG_W-1:0] LIMIT_RST = 8'd255;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FLOOR = 1'b0,
		REG_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 3'd0,
		CMD_STOP  = 3'd1,
		CMD_BOTH  = 3'd2,
		CMD_LEFT  = 3'd3,
		CMD_RIGHT = 3'd4
	} cmd_t;

endpackage

FILE: hdl/dmdr_if.sv
// ----------------------------------------------------------------------------
// dmdr_if
// Valid/ready channels of the duty ramp: command items in, duty items out.
// ----------------------------------------------------------------------------
interface dmdr_cmd_if;
	logic                                   valid;
	logic                                   ready;
	logic [dmdr_pkg::CMD_W-1:0]             command;
	logic signed [dmdr_pkg::SPEED_W-1:0]    speed;

	modport source (output valid, command, speed, input ready);
	modport sink (input valid, command, speed, output ready);
endinterface

interface dmdr_duty_if;
	logic                                   valid;
	logic                                   ready;
	logic [dmdr_pkg::DUTY_OUT_W-1:0]        duty_a;
	logic [dmdr_pkg::DUTY_OUT_W-1:0]        duty_b;
	logic                                   busy_res;
	logic                                   rejected;

	modport source (output valid, duty_a, duty_b, busy_res, rejected, input ready);
	modport sink (input valid, duty_a, duty_b, busy_res, rejected, output ready);
endinterface

FILE: hdl/dual_motor_duty_ramp.sv
// ----------------------------------------------------------------------------
// dual_motor_duty_ramp
// Two-channel PWM duty ramp with slew limiting and turn sequencing.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : valid/ready input channel; each item is a tick or a command
//          (stop, both to speed, turn left, turn right) with a signed speed.
//   duty : valid/ready output channel; exactly one item per input item with
//          both duties, the busy flag and the rejected flag.
//   APB  : duty_floor at 0x0, duty_limit at 0x4; write only while idle.
//   Flow: the accepting edge loads the input register, and the item moves
//          on into the result register once that is empty or being read;
//          output valid comes from the result register.
//          Throughput: one item per cycle while the receiver keeps taking results;
//          the step, saturation and done check all sit between those two registers.
//   The input stays ready while a finished result waits, as long as the
//   input register is free; a stalled receiver holds the result register
//   and backs up the input after one more item.
//   Reset: duties, target and ramp mode clear to zero / idle, floor to 0,
//   limit to 255, both channels empty.
// ----------------------------------------------------------------------------
module dual_motor_duty_ramp #(
	parameter int DUTY_BITS = dmdr_pkg::DUTY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dmdr_cmd_if.sink                      cmd,
	dmdr_duty_if.source                   duty,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dmdr_pkg::PADDR_W-1:0]  paddr,
	input  logic [dmdr_pkg::PDATA_W-1:0]  pwdata,
	output logic [dmdr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_BOTH  = 2'd1,
		MODE_LEFT  = 2'd2,
		MODE_RIGHT = 2'd3
	} mode_t;

	localparam int SW = dmdr_pkg::SPEED_W;
	localparam int CW = dmdr_pkg::CFG_W;

	// configuration
	logic [CW-1:0]                   floor_q;
	logic [CW-1:0]                   limit_q;
	logic                            cfg_wr;
	dmdr_pkg::reg_idx_t              cfg_idx;

	// input register
	logic                            valid_s1;
	logic [dmdr_pkg::CMD_W-1:0]      command_s1;
	logic signed [SW-1:0]            speed_s1;

	// ramp state
	logic [DUTY_BITS-1:0]            duty_a_q;
	logic [DUTY_BITS-1:0]            duty_b_q;
	logic [DUTY_BITS-1:0]            target_q;
	mode_t                           mode_q;

	// result register
	logic                            out_valid_q;
	logic [dmdr_pkg::DUTY_OUT_W-1:0] out_a_q;
	logic [dmdr_pkg::DUTY_OUT_W-1:0] out_b_q;
	logic                            out_busy_q;
	logic                            out_rej_q;

	logic                            accept;
	logic                            advance;
	logic [CW-1:0]                   sat;
	logic [DUTY_BITS-1:0]            a_n;
	logic [DUTY_BITS-1:0]            b_n;
	logic [DUTY_BITS-1:0]            t_n;
	mode_t                           m_n;
	mode_t                           m_cmd;
	logic                            rej_n;
	logic                            done_n;

	function automatic logic [DUTY_BITS-1:0] step_toward(
		input logic [DUTY_BITS-1:0] cur,
		input logic [DUTY_BITS-1:0] tgt
	);
		logic [DUTY_BITS-1:0] res;
		res = cur;
		if (cur < tgt) begin
			res = cur + DUTY_BITS'(1);
		end else if (cur > tgt) begin
			res = cur - DUTY_BITS'(1);
		end
		return res;
	endfunction

	// APB
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = dmdr_pkg::reg_idx_t'(paddr[dmdr_pkg::PADDR_W-1:2]);

	always_comb begin
		unique case (cfg_idx)
			dmdr_pkg::REG_FLOOR: prdata = dmdr_pkg::PDATA_W'(floor_q);
			dmdr_pkg::REG_LIMIT: prdata = dmdr_pkg::PDATA_W'(limit_q);
			default:             prdata = '0;
		endcase
	end

	// handshake
	assign advance   = valid_s1 && (!out_valid_q || duty.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign accept    = cmd.valid && cmd.ready;

	assign duty.valid    = out_valid_q;
	assign duty.duty_a   = out_a_q;
	assign duty.duty_b   = out_b_q;
	assign duty.busy_res = out_busy_q;
	assign duty.rejected = out_rej_q;

	// saturate speed: floor tested first
	always_comb begin
		if (speed_s1 < $signed({{(SW-CW){1'b0}}, floor_q})) begin
			sat = floor_q;
		end else if (speed_s1 > $signed({{(SW-CW){1'b0}}, limit_q})) begin
			sat = limit_q;
		end else begin
			sat = speed_s1[CW-1:0];
		end
	end

	always_comb begin
		unique case (command_s1)
			dmdr_pkg::CMD_LEFT:  m_cmd = MODE_LEFT;
			dmdr_pkg::CMD_RIGHT: m_cmd = MODE_RIGHT;
			default:             m_cmd = MODE_BOTH;
		endcase
	end

	// next ramp state for the item in the input register
	always_comb begin
		a_n   = duty_a_q;
		b_n   = duty_b_q;
		t_n   = target_q;
		m_n   = mode_q;
		rej_n = 1'b0;
		case (command_s1) inside
			dmdr_pkg::CMD_TICK: begin
				case (mode_q)
					MODE_BOTH: begin
						a_n = step_toward(duty_a_q, target_q);
						b_n = step_toward(duty_b_q, target_q);
					end
					MODE_LEFT: begin
						if (duty_a_q != '0) begin
							a_n = duty_a_q - DUTY_BITS'(1);
						end else begin
							b_n = step_toward(duty_b_q, target_q);
						end
					end
					MODE_RIGHT: begin
						if (duty_b_q != '0) begin
							b_n = duty_b_q - DUTY_BITS'(1);
						end else begin
							a_n = step_toward(duty_a_q, target_q);
						end
					end
					default: ;
				endcase
			end
			dmdr_pkg::CMD_STOP: begin
				if (mode_q != MODE_IDLE) begin
					rej_n = 1'b1;
				end else begin
					t_n = '0;
					m_n = MODE_BOTH;
				end
			end
			dmdr_pkg::CMD_BOTH, dmdr_pkg::CMD_LEFT, dmdr_pkg::CMD_RIGHT: begin
				if (mode_q != MODE_IDLE) begin
					rej_n = 1'b1;
				end else begin
					t_n = DUTY_BITS'(sat);
					m_n = m_cmd;
				end
			end
			default: ;
		endcase

		case (m_n)
			MODE_BOTH:  done_n = (a_n == t_n) && (b_n == t_n);
			MODE_LEFT:  done_n = (a_n == '0) && (b_n == t_n);
			MODE_RIGHT: done_n = (b_n == '0) && (a_n == t_n);
			default:    done_n = 1'b1;
		endcase
		if (done_n) begin
			m_n = MODE_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q     <= dmdr_pkg::FLOOR_RST;
			limit_q     <= dmdr_pkg::LIMIT_RST;
			valid_s1    <= 1'b0;
			command_s1  <= '0;
			speed_s1    <= '0;
			duty_a_q    <= '0;
			duty_b_q    <= '0;
			target_q    <= '0;
			mode_q      <= MODE_IDLE;
			out_valid_q <= 1'b0;
			out_a_q     <= '0;
			out_b_q     <= '0;
			out_busy_q  <= 1'b0;
			out_rej_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					dmdr_pkg::REG_FLOOR: floor_q <= pwdata[CW-1:0];
					dmdr_pkg::REG_LIMIT: limit_q <= pwdata[CW-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				valid_s1   <= 1'b1;
				command_s1 <= cmd.command;
				speed_s1   <= cmd.speed;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				duty_a_q    <= a_n;
				duty_b_q    <= b_n;
				target_q    <= t_n;
				mode_q      <= m_n;
				out_valid_q <= 1'b1;
				out_a_q     <= dmdr_pkg::DUTY_OUT_W'(a_n);
				out_b_q     <= dmdr_pkg::DUTY_OUT_W'(b_n);
				out_busy_q  <= (m_n != MODE_IDLE);
				out_rej_q   <= rej_n;
			end else if (duty.ready) begin
				// drop the delivered item
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/dmdr_checker.sv
// ----------------------------------------------------------------------------
// dmdr_checker
// Port-level checks of the duty ramp, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_motor_duty_ramp_defines.svh"

module dmdr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [dmdr_pkg::DUTY_OUT_W-1:0] duty_a,
	input logic [dmdr_pkg::DUTY_OUT_W-1:0] duty_b,
	input logic                            busy_res,
	input logic                            rejected
);

	logic [dmdr_pkg::DUTY_OUT_W-1:0] prev_a_q;
	logic [dmdr_pkg::DUTY_OUT_W-1:0] prev_b_q;
	logic [dmdr_pkg::DUTY_OUT_W-1:0] diff_a;
	logic [dmdr_pkg::DUTY_OUT_W-1:0] diff_b;
	logic                            slew_a_ok;
	logic                            slew_b_ok;

	// track the duties of the last delivered item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q <= '0;
			prev_b_q <= '0;
		end else if (out_valid && out_ready) begin
			prev_a_q <= duty_a;
			prev_b_q <= duty_b;
		end
	end

	assign diff_a    = duty_a - prev_a_q;
	assign diff_b    = duty_b - prev_b_q;
	assign slew_a_ok = (diff_a == '0) || (diff_a == 8'd1) || (diff_a == 8'hff);
	assign slew_b_ok = (diff_b == '0) || (diff_b == 8'd1) || (diff_b == 8'hff);

	`DMDR_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(duty_a) && $stable(duty_b) && $stable(busy_res) && $stable(rejected), "result changed while stalled")
	`DMDR_ASSERT_NOW(a_rej_busy, out_valid && rejected, busy_res, "rejected item without busy ramp")
	`DMDR_ASSERT_NOW(a_slew_a, out_valid, slew_a_ok, "channel A moved by more than one step")
	`DMDR_ASSERT_NOW(a_slew_b, out_valid, slew_b_ok, "channel B moved by more than one step")

endmodule

bind dual_motor_duty_ramp dmdr_checker u_dmdr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (duty.valid),
	.out_ready (duty.ready),
	.duty_a    (duty.duty_a),
	.duty_b    (duty.duty_b),
	.busy_res  (duty.busy_res),
	.rejected  (duty.rejected)
);

FILE: test/dual_motor_duty_ramp_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_motor_duty_ramp_tb
// Self-checking bench for the two-channel duty ramp. Drives tick and command
// items with random gaps and back-pressure, predicts duties, busy and reject
// flags for every item, and sweeps duty floor and limit across their extremes.
// ----------------------------------------------------------------------------
module dual_motor_duty_ramp_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 6;

	localparam logic [dmdr_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [dmdr_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

	typedef enum logic [1:0] {
		RAMP_IDLE  = 2'd0,
		RAMP_BOTH  = 2'd1,
		RAMP_LEFT  = 2'd2,
		RAMP_RIGHT = 2'd3
	} ramp_t;

	typedef struct packed {
		logic [dmdr_pkg::DUTY_OUT_W-1:0] duty_a;
		logic [dmdr_pkg::DUTY_OUT_W-1:0] duty_b;
		logic                            busy_res;
		logic                            rejected;
	} duty_item_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [dmdr_pkg::PADDR_W-1:0]  paddr;
	logic [dmdr_pkg::PDATA_W-1:0]  pwdata;
	logic [dmdr_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;

	dmdr_cmd_if  cmd_ch();
	dmdr_duty_if duty_ch();

	dual_motor_duty_ramp u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.duty    (duty_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted block state
	logic [dmdr_pkg::CFG_W-1:0]      floor_now;
	logic [dmdr_pkg::CFG_W-1:0]      limit_now;
	logic [dmdr_pkg::DUTY_OUT_W-1:0] duty_a_now;
	logic [dmdr_pkg::DUTY_OUT_W-1:0] duty_b_now;
	logic [dmdr_pkg::DUTY_OUT_W-1:0] target_now;
	ramp_t                           ramp_state;

	duty_item_t expected_duty[$];

	int  errors;
	int  items_sent;
	int  results_checked;
	int  rejects_seen;
	int  ramps_finished;
	int  settings_used;
	int  cycle_count;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  holding;
	event hold_ev;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_duty.size());
			$display("dual_motor_duty_ramp regression: fail");
			$finish;
		end
	end

	// receiver ready; a long hold-off overrides the random stalls
	always @(negedge clk) begin
		duty_ch.ready <= !holding && ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		holding = 1'b0;
		forever begin
			@(hold_ev);
			@(posedge clk);
			holding = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding = 1'b0;
		end
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("mismatch at result %0d: %s", results_checked, msg);
	endtask

	always @(posedge clk) begin
		duty_item_t got;
		duty_item_t want;
		if (arst_n && duty_ch.valid && duty_ch.ready) begin
			got = '{duty_ch.duty_a, duty_ch.duty_b, duty_ch.busy_res, duty_ch.rejected};
			if (expected_duty.size() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				want = expected_duty.pop_front();
				if (got.duty_a !== want.duty_a)
					report_mismatch($sformatf("duty_a expected %0d got %0d",
						want.duty_a, got.duty_a));
				if (got.duty_b !== want.duty_b)
					report_mismatch($sformatf("duty_b expected %0d got %0d",
						want.duty_b, got.duty_b));
				if (got.busy_res !== want.busy_res)
					report_mismatch($sformatf("busy_res expected %0d got %0d",
						want.busy_res, got.busy_res));
				if (got.rejected !== want.rejected)
					report_mismatch($sformatf("rejected expected %0d got %0d",
						want.rejected, got.rejected));
			end
			results_checked++;
		end
	end

	function automatic logic [dmdr_pkg::DUTY_OUT_W-1:0] step_to(
		input logic [dmdr_pkg::DUTY_OUT_W-1:0] cur,
		input logic [dmdr_pkg::DUTY_OUT_W-1:0] tgt);
		if (cur < tgt)
			return cur + 1'b1;
		if (cur > tgt)
			return cur - 1'b1;
		return cur;
	endfunction

	function automatic logic [dmdr_pkg::DUTY_OUT_W-1:0] clamp_speed(
		input logic signed [dmdr_pkg::SPEED_W-1:0] spd);
		int s;
		s = spd;
		// floor tested first: with crossed floor and limit, speeds below the floor take the floor, others the limit
		if (s < int'(floor_now))
			return floor_now;
		if (s > int'(limit_now))
			return limit_now;
		return s[dmdr_pkg::DUTY_OUT_W-1:0];
	endfunction

	function automatic bit ramp_reached();
		case (ramp_state)
			RAMP_BOTH:  return duty_a_now == target_now && duty_b_now == target_now;
			RAMP_LEFT:  return duty_a_now == '0 && duty_b_now == target_now;
			RAMP_RIGHT: return duty_b_now == '0 && duty_a_now == target_now;
			default:    return 1'b1;
		endcase
	endfunction

	task automatic advance_ramp(input logic [dmdr_pkg::CMD_W-1:0] code,
		input logic signed [dmdr_pkg::SPEED_W-1:0] spd, output duty_item_t res);
		logic rej;
		rej = 1'b0;
		case (code)
			dmdr_pkg::CMD_TICK: begin
				case (ramp_state)
					RAMP_BOTH: begin
						duty_a_now = step_to(duty_a_now, target_now);
						duty_b_now = step_to(duty_b_now, target_now);
					end
					RAMP_LEFT: begin
						if (duty_a_now != '0)
							duty_a_now = duty_a_now - 1'b1;
						else
							duty_b_now = step_to(duty_b_now, target_now);
					end
					RAMP_RIGHT: begin
						if (duty_b_now != '0)
							duty_b_now = duty_b_now - 1'b1;
						else
							duty_a_now = step_to(duty_a_now, target_now);
					end
					default: ;
				endcase
			end
			dmdr_pkg::CMD_STOP, dmdr_pkg::CMD_BOTH, dmdr_pkg::CMD_LEFT,
			dmdr_pkg::CMD_RIGHT: begin
				if (ramp_state != RAMP_IDLE) begin
					rej = 1'b1;
					rejects_seen++;
				end else if (code == dmdr_pkg::CMD_STOP) begin
					target_now = '0;
					ramp_state = RAMP_BOTH;
				end else begin
					target_now = clamp_speed(spd);
					ramp_state = (code == dmdr_pkg::CMD_BOTH) ? RAMP_BOTH :
						(code == dmdr_pkg::CMD_LEFT) ? RAMP_LEFT : RAMP_RIGHT;
				end
			end
			default: ;
		endcase
		if (ramp_state != RAMP_IDLE && ramp_reached()) begin
			ramp_state = RAMP_IDLE;
			if (code == dmdr_pkg::CMD_TICK)
				ramps_finished++;
		end
		res = '{duty_a_now, duty_b_now, ramp_state != RAMP_IDLE, rej};
	endtask

	task automatic send_item(input logic [dmdr_pkg::CMD_W-1:0] code,
		input logic signed [dmdr_pkg::SPEED_W-1:0] spd);
		duty_item_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= code;
		cmd_ch.speed   <= spd;
		do @(posedge clk); while (!cmd_ch.ready);
		advance_ramp(code, spd, res);
		expected_duty.push_back(res);
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (expected_duty.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input dmdr_pkg::reg_idx_t idx,
		input logic [dmdr_pkg::CFG_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= dmdr_pkg::PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == dmdr_pkg::REG_FLOOR)
			floor_now = value;
		else
			limit_now = value;
	endtask

	// drain, then load new floor and limit and set the idle mix
	task automatic set_phase(input logic [dmdr_pkg::CFG_W-1:0] floor_v,
		input logic [dmdr_pkg::CFG_W-1:0] limit_v, input int send_pct, input int recv_pct);
		wait_drained();
		write_reg(dmdr_pkg::REG_FLOOR, floor_v);
		write_reg(dmdr_pkg::REG_LIMIT, limit_v);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		settings_used++;
	endtask

	task automatic tick_until_idle();
		while (ramp_state != RAMP_IDLE)
			send_item(dmdr_pkg::CMD_TICK, dmdr_pkg::SPEED_W'($urandom));
	endtask

	function automatic logic signed [dmdr_pkg::SPEED_W-1:0] pick_speed();
		int lo;
		int hi;
		int r;
		lo = ((floor_now < limit_now) ? int'(floor_now) : int'(limit_now)) - 4;
		hi = ((floor_now > limit_now) ? int'(floor_now) : int'(limit_now)) + 4;
		r = $urandom_range(99);
		if (r < 30)
			return dmdr_pkg::SPEED_W'($urandom);
		if (r < 80)
			return dmdr_pkg::SPEED_W'(lo + int'($urandom_range(hi - lo)));
		case ($urandom_range(7))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			2:       return 16'sd0;
			3:       return 16'sd255;
			4:       return 16'sd256;
			5:       return -16'sd1;
			6:       return dmdr_pkg::SPEED_W'(floor_now);
			default: return dmdr_pkg::SPEED_W'(limit_now);
		endcase
	endfunction

	function automatic dmdr_pkg::cmd_t pick_command();
		case ($urandom_range(3))
			0:       return dmdr_pkg::CMD_STOP;
			1:       return dmdr_pkg::CMD_BOTH;
			2:       return dmdr_pkg::CMD_LEFT;
			default: return dmdr_pkg::CMD_RIGHT;
		endcase
	endfunction

	// mostly command followed by ticks; some stray commands and unused codes
	task automatic send_random(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (ramp_state == RAMP_IDLE) begin
				if (r < 70)
					send_item(pick_command(), pick_speed());
				else if (r < 88)
					send_item(dmdr_pkg::CMD_TICK, pick_speed());
				else
					send_item(CMD_UNUSED_FIRST + dmdr_pkg::CMD_W'($urandom_range(2)),
						pick_speed());
			end else begin
				if (r < 88)
					send_item(dmdr_pkg::CMD_TICK, pick_speed());
				else if (r < 95)
					send_item(pick_command(), pick_speed());
				else
					send_item(CMD_UNUSED_FIRST + dmdr_pkg::CMD_W'($urandom_range(2)),
						pick_speed());
			end
		end
	endtask

	task automatic test_directed();
		set_phase(8'd0, 8'd3, 22, 73);
		send_item(dmdr_pkg::CMD_TICK, 16'sd0);
		for (logic [dmdr_pkg::CMD_W-1:0] c = CMD_UNUSED_FIRST; c != CMD_UNUSED_FIRST - 1'b1;
			c++) begin
			send_item(c, 16'sd1);
			if (c == CMD_UNUSED_LAST)
				break;
		end
		send_item(dmdr_pkg::CMD_STOP, 16'sh7fff);
		send_item(dmdr_pkg::CMD_BOTH, 16'sh8000);
		send_item(dmdr_pkg::CMD_BOTH, 16'sh7fff);
		send_item(dmdr_pkg::CMD_BOTH, 16'sd3);
		tick_until_idle();
		send_item(dmdr_pkg::CMD_LEFT, 16'sd1);
		tick_until_idle();
		send_item(dmdr_pkg::CMD_RIGHT, 16'sd2);
		tick_until_idle();
		send_item(dmdr_pkg::CMD_STOP, 16'sd0);
		tick_until_idle();
	endtask

	task automatic test_setting_sweep();
		set_phase(8'd0, 8'd255, 22, 73);
		send_random(300);
		set_phase(8'd0, 8'd24, 22, 73);
		send_random(300);
		set_phase(8'd10, 8'd40, 73, 22);
		send_random(300);
		// crossed floor and limit
		set_phase(8'd50, 8'd12, 73, 22);
		send_random(250);
		set_phase(8'd255, 8'd255, 0, 0);
		send_random(150);
		set_phase(8'd0, 8'd0, 0, 0);
		send_random(150);
	endtask

	task automatic test_backpressure();
		set_phase(8'd0, 8'd16, 0, 0);
		-> hold_ev;
		send_random(120);
	endtask

	task automatic test_drain_pause();
		set_phase(8'd5, 8'd20, 0, 0);
		send_random(40);
		wait_drained();
		send_random(40);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = dmdr_pkg::CMD_TICK;
		cmd_ch.speed = '0;
		floor_now = dmdr_pkg::FLOOR_RST;
		limit_now = dmdr_pkg::LIMIT_RST;
		duty_a_now = '0;
		duty_b_now = '0;
		target_now = '0;
		ramp_state = RAMP_IDLE;
		errors = 0;
		items_sent = 0;
		results_checked = 0;
		rejects_seen = 0;
		ramps_finished = 0;
		settings_used = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_setting_sweep();
		test_backpressure();
		test_drain_pause();

		wait_drained();
		$display("checked %0d results for %0d items over %0d floor/limit settings",
			results_checked, items_sent, settings_used);
		$display("%0d ramps ran to completion, %0d commands turned away while busy",
			ramps_finished, rejects_seen);
		if (errors == 0 && expected_duty.size() == 0) begin
			$display("dual_motor_duty_ramp regression: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_duty.size());
			$display("dual_motor_duty_ramp regression: fail");
		end
		$finish;
	end

endmodule
